// ===== rtl/sudr_pkg.sv =====
`default_nettype none
package sudr_pkg;

  // port width of every operand and result field
  localparam int DATA_W = 64;

  // default operating width, 32..64
  localparam int WIDTH_DEF = 64;

  // per-beat control that rides along the divider chain
  typedef struct packed {
    logic valid;
    logic neg_q;
    logic neg_r;
  } sudr_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/sudr_prep.sv =====
`default_nettype none
module sudr_prep #(
  parameter int WIDTH = sudr_pkg::WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic                     in_is_signed,
  input  wire logic [WIDTH-1:0]         in_dividend,
  input  wire logic [WIDTH-1:0]         in_divisor,
  output sudr_pkg::sudr_ctl_t           out_ctl,
  output logic      [WIDTH-1:0]         out_rem,
  output logic      [WIDTH-1:0]         out_dq,
  output logic      [WIDTH-1:0]         out_div
);

  sudr_pkg::sudr_ctl_t ctl_r, ctl_nxt;
  logic [WIDTH-1:0]    dq_r, dq_nxt;
  logic [WIDTH-1:0]    div_r, div_nxt;
  logic                div_zero;
  logic                na;
  logic                nb;

  // A zero divisor keeps the raw dividend and no sign fixup, so the plain
  // restoring chain yields all ones and the dividend. Signed overflow falls
  // out of the magnitude path on its own.
  always_comb begin
    div_zero      = (in_divisor == '0);
    na            = in_is_signed & in_dividend[WIDTH-1] & ~div_zero;
    nb            = in_is_signed & in_divisor[WIDTH-1];
    dq_nxt        = na ? (~in_dividend + 1'b1) : in_dividend;
    div_nxt       = nb ? (~in_divisor + 1'b1) : in_divisor;
    ctl_nxt.valid = in_valid;
    ctl_nxt.neg_q = na ^ nb;
    ctl_nxt.neg_r = na;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    div_r <= div_nxt;
  end

  assign out_ctl = ctl_r;
  assign out_rem = '0;
  assign out_dq  = dq_r;
  assign out_div = div_r;

endmodule
`default_nettype wire

// ===== rtl/sudr_cell.sv =====
`default_nettype none
module sudr_cell #(
  parameter int WIDTH = sudr_pkg::WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sudr_pkg::sudr_ctl_t      in_ctl,
  input  wire logic [WIDTH-1:0]         in_rem,
  input  wire logic [WIDTH-1:0]         in_dq,
  input  wire logic [WIDTH-1:0]         in_div,
  output sudr_pkg::sudr_ctl_t           out_ctl,
  output logic      [WIDTH-1:0]         out_rem,
  output logic      [WIDTH-1:0]         out_dq,
  output logic      [WIDTH-1:0]         out_div
);

  sudr_pkg::sudr_ctl_t ctl_r;
  logic [WIDTH-1:0]    rem_r, rem_nxt;
  logic [WIDTH-1:0]    dq_r, dq_nxt;
  logic [WIDTH-1:0]    div_r;
  logic [WIDTH:0]      trial;
  logic [WIDTH:0]      diff;
  logic                ge;

  // one restoring step: dividend bits leave at the top of dq while
  // quotient bits enter at the bottom
  always_comb begin
    trial   = {in_rem, in_dq[WIDTH-1]};
    diff    = trial - {1'b0, in_div};
    ge      = ~diff[WIDTH];
    rem_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    dq_nxt  = {in_dq[WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    div_r <= in_div;
  end

  assign out_ctl = ctl_r;
  assign out_rem = rem_r;
  assign out_dq  = dq_r;
  assign out_div = div_r;

endmodule
`default_nettype wire

// ===== rtl/sudr_post.sv =====
`default_nettype none
module sudr_post #(
  parameter int WIDTH = sudr_pkg::WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sudr_pkg::sudr_ctl_t             in_ctl,
  input  wire logic [WIDTH-1:0]                in_rem,
  input  wire logic [WIDTH-1:0]                in_quo,
  output logic                                 out_valid,
  output logic      [sudr_pkg::DATA_W-1:0]     out_quotient,
  output logic      [sudr_pkg::DATA_W-1:0]     out_remainder
);

  logic                        valid_r;
  logic [WIDTH-1:0]            quo_r, quo_nxt;
  logic [WIDTH-1:0]            rem_r, rem_nxt;

  always_comb begin
    quo_nxt = in_ctl.neg_q ? (~in_quo + 1'b1) : in_quo;
    rem_nxt = in_ctl.neg_r ? (~in_rem + 1'b1) : in_rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign out_valid     = valid_r;
  assign out_quotient  = sudr_pkg::DATA_W'(quo_r);
  assign out_remainder = sudr_pkg::DATA_W'(rem_r);

endmodule
`default_nettype wire

// ===== rtl/signed_unsigned_divider_rem.sv =====
`default_nettype none
// Pipelined integer divider, RISC-V M rules: quotient and remainder.
// Input: a beat is taken at each clock edge with start high and busy low.
//   busy is always low, so a beat may be issued every cycle. A beat with
//   in_enable low is taken and dropped. Only the low WIDTH bits of
//   in_dividend and in_divisor are used; in_signed_op picks two's complement.
// Output: out_valid is high for exactly one cycle per enabled beat, with
//   out_quotient and out_remainder zero-extended to 64 bits. Results come
//   out in issue order.
// Stages: registered operand conditioning (absolute values), WIDTH
//   restoring-division cells, one bit per cell, and sign fixup into the
//   output register.
// Throughput: one beat per cycle; each cell of the chain holds one beat.
// Divide by zero: quotient all ones, remainder the dividend. Signed most
//   negative over minus one: quotient the dividend, remainder zero.
// Reset (rst_n low, synchronous) drops every beat in flight.
// The receiver cannot stall; each result is shown for its one cycle only.
module signed_unsigned_divider_rem #(
  parameter int WIDTH = sudr_pkg::WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_enable,
  input  wire logic                            in_signed_op,
  input  wire logic [sudr_pkg::DATA_W-1:0]     in_dividend,
  input  wire logic [sudr_pkg::DATA_W-1:0]     in_divisor,
  output logic                                 out_valid,
  output logic      [sudr_pkg::DATA_W-1:0]     out_quotient,
  output logic      [sudr_pkg::DATA_W-1:0]     out_remainder
);

  localparam int LAT = WIDTH + 2;

  sudr_pkg::sudr_ctl_t ctl  [WIDTH+1];
  logic [WIDTH-1:0]    rem  [WIDTH+1];
  logic [WIDTH-1:0]    dq   [WIDTH+1];
  logic [WIDTH-1:0]    dvs  [WIDTH+1];
  logic                take;

  assign busy = 1'b0;
  assign take = start & ~busy & in_enable;

  sudr_prep #(.WIDTH(WIDTH)) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (take),
    .in_is_signed (in_signed_op),
    .in_dividend  (in_dividend[WIDTH-1:0]),
    .in_divisor   (in_divisor[WIDTH-1:0]),
    .out_ctl      (ctl[0]),
    .out_rem      (rem[0]),
    .out_dq       (dq[0]),
    .out_div      (dvs[0])
  );

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    sudr_cell #(.WIDTH(WIDTH)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (ctl[i]),
      .in_rem  (rem[i]),
      .in_dq   (dq[i]),
      .in_div  (dvs[i]),
      .out_ctl (ctl[i+1]),
      .out_rem (rem[i+1]),
      .out_dq  (dq[i+1]),
      .out_div (dvs[i+1])
    );
  end

  sudr_post #(.WIDTH(WIDTH)) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ctl        (ctl[WIDTH]),
    .in_rem        (rem[WIDTH]),
    .in_quo        (dq[WIDTH]),
    .out_valid     (out_valid),
    .out_quotient  (out_quotient),
    .out_remainder (out_remainder)
  );

`ifndef SYNTHESIS
  // every result traces back to an enabled beat that was accepted
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_enable, LAT))
    else $error("result without a matching issued beat");

  // divide by zero gives all ones and the dividend, in either mode
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_divisor[WIDTH-1:0] == '0, LAT)) |->
      (out_quotient[WIDTH-1:0] == {WIDTH{1'b1}} &&
       out_remainder[WIDTH-1:0] == $past(in_dividend[WIDTH-1:0], LAT)))
    else $error("divide by zero result wrong");

  // unsigned remainders stay below a nonzero divisor
  a_unsigned_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(in_signed_op, LAT) &&
     $past(in_divisor[WIDTH-1:0] != '0, LAT)) |->
      (out_remainder[WIDTH-1:0] < $past(in_divisor[WIDTH-1:0], LAT)))
    else $error("unsigned remainder not below divisor");
`endif

endmodule
`default_nettype wire
